/* sv/stereo_feedback_delay_assert.svh */
// Assertion macros used by the stereo feedback delay controller.
// Depends on nothing; included by files that carry assertions.
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sfd_pkg.sv */
// Package for the stereo feedback delay: types, constants and helpers.
// Used by stereo_feedback_delay, sfd_ctrl, sfd_datapath, sfd_cfg_if and the testbench.
package sfd_pkg;

  localparam int LINE_LENGTH_DEF = 131072;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 25;
  localparam int COEF_W = 24;
  localparam int ACC_W = 32;
  localparam int FB_MAX = 62259;
  localparam int MIX_FULL = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_DELAY = 3'd1,
    REG_FB_GAIN = 3'd2,
    REG_MIX_GAIN = 3'd3,
    REG_MODE = 3'd4,
    REG_LP_B0 = 3'd5,
    REG_LP_A1 = 3'd6,
    REG_LP_A2 = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADDR,
    ST_READ0,
    ST_READ1,
    ST_INTERP,
    ST_FEEDBACK,
    ST_FILTER_Y,
    ST_FILTER_S,
    ST_WRITE,
    ST_OUT
  } sfd_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       clear_en;
    logic       load;
    logic       addr;
    logic       rd_first;
    logic       rd_second;
    logic       interp;
    logic       feedback;
    logic       filt_y;
    logic       filt_s;
    logic       write;
    logic       bypass;
  } sfd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
  } sfd_stat_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    else if (v < -64'sd2147483648) return -64'sd2147483648;
    else return v;
  endfunction

endpackage

/* sv/sfd_stream_if.sv */
// Valid/ready stream interface carrying one stereo frame.
// Depends on nothing.
interface sfd_stream_if #(parameter int W = 24);
  logic valid;
  logic ready;
  logic signed [W-1:0] left;
  logic signed [W-1:0] right;
  modport source (output valid, left, right, input ready);
  modport sink (input valid, left, right, output ready);
endinterface

/* sv/sfd_cfg_if.sv */
// Configuration write channel: register index and data.
// Depends on sfd_pkg.
interface sfd_cfg_if import sfd_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/stereo_feedback_delay.sv */
// Channel     | dir | payload
// in_         | in  | left, right
// out_        | out | left, right
// cfg_        | in  | index, data
// An enabled frame makes two reads through each line's single RAM port, then
// interpolation, feedback, the filter (with damping) and the write.
// A disabled frame goes from idle straight to the output. After reset a clearing
// pass zeroes the lines; no frame is accepted then. A result waits in the
// output register until taken; the next frame is accepted after that.
module stereo_feedback_delay import sfd_pkg::*; #(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  sfd_stream_if.sink in_s,
  sfd_stream_if.source out_s,
  sfd_cfg_if.sink cfg_s
);
  logic enable_r;
  logic [24:0] delay_r;
  logic [15:0] fb_r;
  logic [16:0] mix_r;
  logic [1:0] mode_r;
  logic signed [COEF_W-1:0] b0_r, a1_r, a2_r;
  sfd_cmd_t cmd;
  sfd_stat_t stat;

  assign cfg_s.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0; delay_r <= 25'd256; fb_r <= '0; mix_r <= '0;
      mode_r <= '0; b0_r <= '0; a1_r <= '0; a2_r <= '0;
    end else if (cfg_s.valid) begin
      unique case (reg_idx_t'(cfg_s.index))
        REG_ENABLE:   enable_r <= cfg_s.data[0];
        REG_DELAY:    delay_r <= cfg_s.data;
        REG_FB_GAIN:  fb_r <= cfg_s.data[15:0];
        REG_MIX_GAIN: mix_r <= cfg_s.data[16:0];
        REG_MODE:     mode_r <= cfg_s.data[1:0];
        REG_LP_B0:    b0_r <= cfg_s.data[23:0];
        REG_LP_A1:    a1_r <= cfg_s.data[23:0];
        REG_LP_A2:    a2_r <= cfg_s.data[23:0];
        default:      ;
      endcase
    end
  end

  sfd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
    .out_valid(out_s.valid), .out_ready(out_s.ready), .enable(enable_r),
    .damp(mode_r[1]), .stat(stat), .cmd(cmd));

  sfd_datapath #(.LINE_LENGTH(LINE_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_l(in_s.left), .in_r(in_s.right), .delay_time(delay_r), .fb_gain(fb_r),
    .mix_gain(mix_r), .mode(mode_r), .b0(b0_r), .a1(a1_r), .a2(a2_r),
    .out_l(out_s.left), .out_r(out_s.right));
endmodule

/* sv/sfd_ram.sv */
// Generic single-port RAM, registered read.
// Depends on nothing.
module sfd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/sfd_ctrl.sv */
// Controller state machine of the stereo feedback delay.
// Depends on sfd_pkg and the assertion macro header.
`include "stereo_feedback_delay_assert.svh"
module sfd_ctrl import sfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      enable,
  input  logic      damp,
  input  sfd_stat_t stat,
  output sfd_cmd_t  cmd
);
  sfd_state_t state_r, state_nxt;
  logic pending_r, pending_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (stat.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid && !pending_r) state_nxt = enable ? ST_ADDR : ST_OUT;
      ST_ADDR:     state_nxt = ST_READ0;
      ST_READ0:    state_nxt = ST_READ1;
      ST_READ1:    state_nxt = ST_INTERP;
      ST_INTERP:   state_nxt = ST_FEEDBACK;
      ST_FEEDBACK: state_nxt = damp ? ST_FILTER_Y : ST_WRITE;
      ST_FILTER_Y: state_nxt = ST_FILTER_S;
      ST_FILTER_S: state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state_r == ST_IDLE) && !pending_r;
    cmd.load = in_valid && in_ready;
    cmd.bypass = !enable;
    unique case (state_r)
      ST_CLEAR:    cmd.clear_en = 1'b1;
      ST_ADDR:     cmd.addr = 1'b1;
      ST_READ0:    cmd.rd_first = 1'b1;
      ST_READ1:    cmd.rd_second = 1'b1;
      ST_INTERP:   cmd.interp = 1'b1;
      ST_FEEDBACK: cmd.feedback = 1'b1;
      ST_FILTER_Y: cmd.filt_y = 1'b1;
      ST_FILTER_S: cmd.filt_s = 1'b1;
      ST_WRITE:    cmd.write = 1'b1;
      default:     ;
    endcase
  end

  // The result register stays full until the sink takes it.
  always_comb begin
    pending_nxt = pending_r;
    if (out_valid && out_ready) pending_nxt = 1'b0;
    if (state_r == ST_OUT) pending_nxt = 1'b1;
  end
  assign out_valid = pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pending_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pending_r <= pending_nxt;
    end
  end

  `SFD_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_valid && in_ready, state_r == ST_IDLE, "accept outside idle")
  `SFD_ASSERT_NEXT(a_out_sets, clk, rst_n, state_r == ST_OUT, out_valid, "result not presented")
  `SFD_ASSERT_IMP(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !in_ready && !out_valid, "activity while clearing")
endmodule

/* sv/sfd_datapath.sv */
// Datapath: delay lines, interpolation, feedback, lowpass and mix.
// Depends on sfd_pkg and sfd_ram.
module sfd_datapath import sfd_pkg::*; #(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfd_cmd_t                      cmd,
  output sfd_stat_t                     stat,
  input  logic signed [SAMPLE_BITS-1:0] in_l,
  input  logic signed [SAMPLE_BITS-1:0] in_r,
  input  logic [24:0]                   delay_time,
  input  logic [15:0]                   fb_gain,
  input  logic [16:0]                   mix_gain,
  input  logic [1:0]                    mode,
  input  logic signed [COEF_W-1:0]      b0,
  input  logic signed [COEF_W-1:0]      a1,
  input  logic signed [COEF_W-1:0]      a2,
  output logic signed [SAMPLE_BITS-1:0] out_l,
  output logic signed [SAMPLE_BITS-1:0] out_r
);
  localparam int AW = $clog2(LINE_LENGTH);
  localparam int LW = SAMPLE_BITS + 2;
  localparam int F = SAMPLE_BITS - 1;
  localparam int RW = AW + 8;
  localparam logic [RW:0] DMAX = RW'(LINE_LENGTH - 2) << 8;

  logic signed [SAMPLE_BITS-1:0] x_r [2];
  logic [AW-1:0] wp_r, i_r, j_r, addr, clr_r;
  logic [7:0] f_r;
  logic signed [LW-1:0] a_r [2], rd [2], wdat [2];
  logic signed [LW-1:0] del_r [2];
  logic signed [LW-1:0] fb_r [2];
  logic signed [ACC_W-1:0] s1_r [2], s2_r [2], y_r [2];
  logic we;
  logic signed [SAMPLE_BITS-1:0] o_r [2];

  logic [RW:0] d, r;
  always_comb begin
    d = (RW+1)'(delay_time);
    if (delay_time > 25'(DMAX)) d = DMAX;
    if (delay_time < 25'd256) d = (RW+1)'(256);
    r = {1'b0, wp_r, 8'd0} - d;
    if (r[RW]) r = r + ((RW+1)'(LINE_LENGTH) << 8);
  end

  assign addr = cmd.clear_en ? clr_r : (cmd.write ? wp_r : (cmd.addr ? i_r : j_r));
  assign we = cmd.clear_en || cmd.write;
  assign stat.clear_done = (clr_r == AW'(LINE_LENGTH - 1));

  for (genvar c = 0; c < 2; c++) begin : g_ch
    sfd_ram #(.WIDTH(LW), .DEPTH(LINE_LENGTH)) u_line (
      .clk(clk), .we(we), .addr(addr),
      .wdata(cmd.clear_en ? '0 : wdat[c]), .rdata(rd[c]));
  end

  logic [16:0] g, m;
  assign g = (fb_gain > 16'(FB_MAX)) ? 17'(FB_MAX) : {1'b0, fb_gain};
  assign m = (mix_gain > 17'(MIX_FULL)) ? 17'(MIX_FULL) : mix_gain;

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
    input logic signed [63:0] lo, input logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  logic signed [63:0] lmax, lmin, smax, smin;
  assign lmax = (64'sd4 <<< F) - 64'sd1;
  assign lmin = -(64'sd4 <<< F);
  assign smax = (64'sd1 <<< F) - 64'sd1;
  assign smin = -(64'sd1 <<< F);

  for (genvar c = 0; c < 2; c++) begin : g_wd
    logic signed [63:0] v;
    assign v = (mode[1] ? y_r[c] : fb_r[c]) + 64'(x_r[c]);
    assign wdat[c] = LW'(clamp(v, lmin, lmax));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      clr_r <= '0;
      s1_r[0] <= '0; s1_r[1] <= '0; s2_r[0] <= '0; s2_r[1] <= '0;
    end else begin
      if (cmd.clear_en) clr_r <= clr_r + AW'(1);
      if (cmd.load) begin
        x_r[0] <= in_l; x_r[1] <= in_r;
        i_r <= r[RW-1:8]; f_r <= r[7:0];
        j_r <= (r[RW-1:8] == AW'(LINE_LENGTH - 1)) ? '0 : r[RW-1:8] + AW'(1);
      end
      for (int c = 0; c < 2; c++) begin
        // The first read returns entry i; entry j arrives in the cycle after.
        if (cmd.rd_first) a_r[c] <= rd[c];
        if (cmd.interp)
          del_r[c] <= LW'((64'(a_r[c]) * $signed({1'b0, 9'd256 - 9'(f_r)})
                          + 64'(rd[c]) * $signed({1'b0, f_r})) >>> 8);
        if (cmd.feedback)
          fb_r[c] <= LW'((64'(mode[0] ? del_r[1-c] : del_r[c]) * $signed({1'b0, g}))
                         >>> 16);
        if (cmd.filt_y)
          y_r[c] <= ACC_W'(sat32(((64'(b0) * fb_r[c]) >>> 22) + s1_r[c]));
        if (cmd.filt_s) begin
          s1_r[c] <= ACC_W'(sat32(((((64'(b0) * fb_r[c]) <<< 1) - 64'(a1) * y_r[c])
                                   >>> 22) + s2_r[c]));
          s2_r[c] <= ACC_W'(sat32((64'(b0) * fb_r[c] - 64'(a2) * y_r[c]) >>> 22));
        end
        if (cmd.write)
          o_r[c] <= SAMPLE_BITS'(clamp((64'(x_r[c]) * $signed({1'b0, 17'(MIX_FULL) - m})
                    + 64'(del_r[c]) * $signed({1'b0, m})) >>> 16, smin, smax));
      end
      if (cmd.write) wp_r <= (wp_r == AW'(LINE_LENGTH - 1)) ? '0 : wp_r + AW'(1);
      if (cmd.load && cmd.bypass) begin
        o_r[0] <= in_l; o_r[1] <= in_r;
      end
    end
  end

  assign out_l = o_r[0];
  assign out_r = o_r[1];
endmodule

/* tb/tb_stereo_feedback_delay.sv */
// Self-checking testbench for stereo_feedback_delay: a frame-level predictor of
// the delay lines, feedback, damping filter and dry/wet mix. Frames are checked in order.
// Depends on sfd_pkg, sfd_stream_if, sfd_cfg_if and stereo_feedback_delay.
`timescale 1ns / 1ps

module tb_stereo_feedback_delay;
  import sfd_pkg::*;

  localparam int LEN = LINE_LENGTH_DEF;
  localparam longint LINE_HI = (64'sd4 <<< 23) - 1;
  localparam longint LINE_LO = -(64'sd4 <<< 23);
  localparam longint SAMP_HI = (64'sd1 <<< 23) - 1;
  localparam longint SAMP_LO = -(64'sd1 <<< 23);
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
  } frame_t;

  logic clk;
  logic rst_n;

  sfd_stream_if #(24) in_if ();
  sfd_stream_if #(24) out_if ();
  sfd_cfg_if cfg_if ();

  stereo_feedback_delay i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_s(in_if),
    .out_s(out_if),
    .cfg_s(cfg_if)
  );

  // Predictor state and register copies.
  int dline[2][LEN];
  int unsigned wr_ptr;
  longint lp_s1[2];
  longint lp_s2[2];
  logic en_q;
  logic [24:0] delay_q;
  logic [15:0] fb_gain_q;
  logic [16:0] mix_q;
  logic [1:0] mode_q;
  longint b0_q, a1_q, a2_q;

  frame_t expected_frames[$];
  int err_count;
  int frames_sent;
  int frames_checked;
  int cfg_phases;
  int burst_left;
  int unsigned stall_cycle;

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = 1'b1;
      #10 clk = 1'b0;
    end
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic frame_t predict_frame(input logic signed [23:0] xl,
                                           input logic signed [23:0] xr);
    longint x[2], del[2], src, fb, y, s1, s2, o, d, rpos, f, g, m;
    int i, j;
    logic [23:0] res[2];
    frame_t fr;
    x[0] = xl;
    x[1] = xr;
    if (!en_q) begin
      fr.left = xl;
      fr.right = xr;
      return fr;
    end
    d = clip(longint'(delay_q), 256, longint'(LEN - 2) * 256);
    rpos = longint'(wr_ptr) * 256 - d;
    if (rpos < 0) rpos += longint'(LEN) * 256;
    i = int'(rpos >>> 8);
    f = rpos & 255;
    j = (i + 1 >= LEN) ? 0 : i + 1;
    for (int ch = 0; ch < 2; ch++)
      del[ch] = (longint'(dline[ch][i]) * (256 - f) + longint'(dline[ch][j]) * f) >>> 8;
    g = (fb_gain_q > FB_MAX) ? FB_MAX : fb_gain_q;
    m = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
    for (int ch = 0; ch < 2; ch++) begin
      src = mode_q[0] ? del[1-ch] : del[ch];
      fb = (src * g) >>> 16;
      if (mode_q[1]) begin
        y = clip(((b0_q * fb) >>> 22) + lp_s1[ch], I32_LO, I32_HI);
        s1 = clip(((2 * b0_q * fb - a1_q * y) >>> 22) + lp_s2[ch], I32_LO, I32_HI);
        s2 = clip((b0_q * fb - a2_q * y) >>> 22, I32_LO, I32_HI);
        lp_s1[ch] = s1;
        lp_s2[ch] = s2;
        fb = y;
      end
      dline[ch][wr_ptr] = int'(clip(x[ch] + fb, LINE_LO, LINE_HI));
      o = (x[ch] * (MIX_FULL - m) + del[ch] * m) >>> 16;
      res[ch] = 24'(clip(o, SAMP_LO, SAMP_HI));
    end
    wr_ptr = (wr_ptr + 1 >= LEN) ? 0 : wr_ptr + 1;
    fr.left = res[0];
    fr.right = res[1];
    return fr;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] exp_v,
                                 input logic [23:0] got_v);
    $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
    err_count++;
  endtask

  // Output stall pattern changes with bits 9:8 of the cycle counter.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= (stall_cycle % 3) == 0;
      2'd2: out_if.ready <= 1'($urandom_range(0, 1));
      default: out_if.ready <= (stall_cycle[3:0] != 4'd0);
    endcase
  end

  // Signals are stable at the falling edge, so a transfer seen here happens at the next rise.
  always @(negedge clk) begin
    frame_t exp_f;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_frames.size() == 0) begin
        $display("unexpected output frame %h %h at %0t", out_if.left, out_if.right,
                 $realtime);
        err_count++;
      end else begin
        exp_f = expected_frames.pop_front();
        frames_checked++;
        if (out_if.left !== exp_f.left) report_mismatch("out_left", exp_f.left, out_if.left);
        if (out_if.right !== exp_f.right)
          report_mismatch("out_right", exp_f.right, out_if.right);
      end
    end
  end

  task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_if.valid <= 1'b1;
    in_if.left <= l;
    in_if.right <= r;
    forever begin
      @(negedge clk);
      if (in_if.ready) break;
      @(posedge clk);
    end
    expected_frames.push_back(predict_frame(l, r));
    frames_sent++;
    burst_left--;
    @(posedge clk);
  endtask

  // Drops the input valid and waits until every expected frame has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [24:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    forever begin
      @(negedge clk);
      if (cfg_if.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_ENABLE: en_q = val[0];
      REG_DELAY: delay_q = val;
      REG_FB_GAIN: fb_gain_q = val[15:0];
      REG_MIX_GAIN: mix_q = val[16:0];
      REG_MODE: mode_q = val[1:0];
      REG_LP_B0: b0_q = longint'($signed(val[23:0]));
      REG_LP_A1: a1_q = longint'($signed(val[23:0]));
      default: a2_q = longint'($signed(val[23:0]));
    endcase
  endtask

  task automatic write_all(input logic en, input logic [24:0] dly, input logic [15:0] fbg,
                           input logic [16:0] mix, input logic [1:0] mode,
                           input logic [23:0] b0, input logic [23:0] a1,
                           input logic [23:0] a2);
    write_reg(REG_ENABLE, 25'(en));
    write_reg(REG_DELAY, dly);
    write_reg(REG_FB_GAIN, 25'(fbg));
    write_reg(REG_MIX_GAIN, 25'(mix));
    write_reg(REG_MODE, 25'(mode));
    write_reg(REG_LP_B0, 25'(b0));
    write_reg(REG_LP_A1, 25'(a1));
    write_reg(REG_LP_A2, 25'(a2));
    cfg_phases++;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 255)) - 24'd128;
      default: return 24'($urandom());
    endcase
  endfunction

  // Pass-through while disabled, including the sample extremes.
  task automatic test_bypass();
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'h555555, 24'hAAAAAA);
  endtask

  // Gain, delay and mode extremes, each with one to four frames.
  task automatic test_extremes();
    write_all(1'b1, 25'd0, 16'hFFFF, 17'h1FFFF, 2'd0, 24'd0, 24'd0, 24'd0);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h123456, 24'hFEDCBA);
    write_all(1'b1, 25'd384, 16'd62259, 17'd32768, 2'd1, 24'd0, 24'd0, 24'd0);
    send_frame(24'h400000, 24'h000000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h000000, 24'hC00000);
    send_frame(24'h000000, 24'h000000);
    write_all(1'b1, 25'h1FFFFFF, 16'd40000, 17'd65536, 2'd2, 24'h7FFFFF, 24'h800000,
              24'h7FFFFF);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000001, 24'hFFFFFF);
    write_all(1'b1, 25'd256, 16'd62259, 17'd65535, 2'd3, 24'h040000, 24'hA00000,
              24'h266666);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h000000, 24'h000000);
    write_all(1'b1, 25'd33553920, 16'd0, 17'd0, 2'd0, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_frame(24'h7FFFFF, 24'h800000);
  endtask

  // Random phases: mostly short delays so the feedback circulates many times.
  task automatic test_random();
    logic [24:0] dly;
    logic [23:0] b0, a1, a2;
    int n;
    while (frames_sent < 1550) begin
      case ($urandom_range(0, 9))
        0: dly = 25'($urandom());
        1: dly = 25'd33553920;
        2: dly = 25'($urandom_range(0, 255));
        default: dly = 25'($urandom_range(256, 256 * 60));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        b0 = 24'($urandom());
        a1 = 24'($urandom());
        a2 = 24'($urandom());
      end else begin
        // A stable lowpass so the damped loop stays in range.
        b0 = 24'($urandom_range(0, 300000));
        a1 = -24'($urandom_range(4000000, 7500000));
        a2 = 24'($urandom_range(1000000, 3800000));
      end
      write_all(($urandom_range(0, 7) != 0), dly, 16'($urandom()),
                ($urandom_range(0, 4) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536)),
                2'($urandom()), b0, a1, a2);
      n = $urandom_range(40, 160);
      repeat (n) send_frame(rand_sample(), rand_sample());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.left = '0;
    in_if.right = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ENABLE;
    cfg_if.data = '0;
    stall_cycle = 0;
    foreach (dline[c, k]) dline[c][k] = 0;
    wr_ptr = 0;
    lp_s1 = '{0, 0};
    lp_s2 = '{0, 0};
    en_q = 1'b0;
    delay_q = 25'd256;
    fb_gain_q = '0;
    mix_q = '0;
    mode_q = '0;
    b0_q = 0;
    a1_q = 0;
    a2_q = 0;
    err_count = 0;
    frames_sent = 0;
    frames_checked = 0;
    cfg_phases = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bypass();
    test_extremes();
    test_random();
    settle();
    repeat (40) @(posedge clk);

    $display("Covered %0d frames over %0d register settings, %0d results checked.",
             frames_sent, cfg_phases, frames_checked);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
